FILE: rtl/core/aesctr_pkg.sv
package aesctr_pkg;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  valid_bytes;
        logic        restart;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [4:0]  result_bytes;
    } t_out_item;

    // classified job handed from front to back
    typedef struct packed {
        logic [127:0] ctr;
        logic [127:0] data;
        logic [4:0]   nbytes;
    } t_job;

    localparam logic [1:0] CFG_KEY_HIGH   = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW    = 2'd1;
    localparam logic [1:0] CFG_START_HIGH = 2'd2;
    localparam logic [1:0] CFG_START_LOW  = 2'd3;
    localparam int         NUM_CFG        = 4;
    localparam int         NUM_ROUNDS     = 10;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // one full round: sub bytes, shift rows, optional mix columns, add key
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic do_mix);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   x;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = sbox(b[4*((c+r)%4)+r]);
        if (do_mix) begin
            for (int c = 0; c < 4; c++) begin
                x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                b[4*c]   = t[4*c]   ^ x ^ gf_double(t[4*c]   ^ t[4*c+1]);
                b[4*c+1] = t[4*c+1] ^ x ^ gf_double(t[4*c+1] ^ t[4*c+2]);
                b[4*c+2] = t[4*c+2] ^ x ^ gf_double(t[4*c+2] ^ t[4*c+3]);
                b[4*c+3] = t[4*c+3] ^ x ^ gf_double(t[4*c+3] ^ t[4*c]);
            end
        end else begin
            for (int i = 0; i < 16; i++) b[i] = t[i];
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = b[i];
        return o ^ k;
    endfunction

    function automatic logic [63:0] lead_mask(input logic [4:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
            if (n > 5'(i)) m[63-8*i -: 8] = 8'hff;
        return m;
    endfunction

endpackage

FILE: rtl/core/aesctr_keyexp.sv
module aesctr_keyexp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [127:0]         i_key,
    output logic [10:0][127:0]   o_rkeys,
    output logic                 o_busy
);
    // one round key per cycle after a key write; expansion of zero key at reset
    logic [10:0][127:0] r_rk;
    logic [3:0]         r_idx;
    logic [7:0]         r_rc;
    logic               r_busy;
    logic [127:0]       w_prev;
    logic [31:0]        w_t;
    logic [127:0]       n_rk;

    always_comb begin
        w_prev = r_rk[r_idx - 4'd1];
        w_t    = aesctr_pkg::sbox_word({w_prev[23:0], w_prev[31:24]}) ^ {r_rc, 24'd0};
        n_rk[127:96] = w_prev[127:96] ^ w_t;
        n_rk[95:64]  = w_prev[95:64]  ^ n_rk[127:96];
        n_rk[63:32]  = w_prev[63:32]  ^ n_rk[95:64];
        n_rk[31:0]   = w_prev[31:0]   ^ n_rk[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rk[0] <= '0;
            r_idx   <= 4'd1;
            r_rc    <= 8'h01;
            r_busy  <= 1'b1;
        end else if (i_load) begin
            r_rk[0] <= i_key;
            r_idx   <= 4'd1;
            r_rc    <= 8'h01;
            r_busy  <= 1'b1;
        end else if (r_busy) begin
            r_rk[r_idx] <= n_rk;
            r_rc        <= aesctr_pkg::gf_double(r_rc);
            r_idx       <= r_idx + 4'd1;
            if (r_idx == 4'(aesctr_pkg::NUM_ROUNDS)) r_busy <= 1'b0;
        end
    end

    assign o_rkeys = r_rk;
    // round keys not yet complete, or a rebuild about to start
    assign o_busy  = r_busy || i_load;
endmodule

FILE: rtl/core/aesctr_front.sv
module aesctr_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  aesctr_pkg::t_in_item  i_item,
    output logic                  o_stall,
    input  logic [127:0]          i_start_ctr,
    output logic                  o_valid,
    output aesctr_pkg::t_job      o_job,
    input  logic                  i_stall
);
    // two-entry queue toward the back; counter advances at each transfer with a nonzero count
    logic [127:0]      r_ctr;
    aesctr_pkg::t_job  r_q [2];
    logic              r_rd, r_wr;
    logic [1:0]        r_cnt;
    logic              w_take, w_give;
    logic [4:0]        w_n;
    logic [127:0]      w_base;

    assign o_stall = (r_cnt == 2'd2);
    assign w_take  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_give  = o_valid && !i_stall;
    assign o_job   = r_q[r_rd];
    assign w_n     = (i_item.valid_bytes > 5'd16) ? 5'd16 : i_item.valid_bytes;
    assign w_base  = i_item.restart ? i_start_ctr : r_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_take) begin
                r_q[r_wr] <= '{ctr: w_base,
                               data: {i_item.data_high, i_item.data_low}, nbytes: w_n};
                r_ctr <= (w_n == 5'd0) ? w_base : w_base + 128'd1;
                r_wr  <= !r_wr;
            end
            if (w_give) r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_take} - {1'b0, w_give};
        end
    end
endmodule

FILE: rtl/core/aesctr_back.sv
module aesctr_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  aesctr_pkg::t_job       i_job,
    output logic                   o_stall,
    input  logic [10:0][127:0]     i_rkeys,
    output logic                   o_valid,
    output aesctr_pkg::t_out_item  o_item,
    input  logic                   i_stall
);
    localparam int NS = aesctr_pkg::NUM_ROUNDS + 1;
    // stage 0 adds the first key, stages 1..10 run rounds; stall freezes all
    logic [NS-1:0]          r_v;
    aesctr_pkg::t_job       r_j [NS];
    logic                   w_adv;
    logic [127:0]           w_ks;

    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_v[NS-1];
    assign w_ks    = r_j[NS-1].ctr ^ r_j[NS-1].data;
    assign o_item  = '{
        result_high:  w_ks[127:64] & aesctr_pkg::lead_mask(r_j[NS-1].nbytes),
        result_low:   w_ks[63:0] & aesctr_pkg::lead_mask(
                          (r_j[NS-1].nbytes > 5'd8) ? r_j[NS-1].nbytes - 5'd8 : 5'd0),
        result_bytes: r_j[NS-1].nbytes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_j[0] <= '{ctr: i_job.ctr ^ i_rkeys[0], data: i_job.data, nbytes: i_job.nbytes};
            for (int s = 1; s < NS; s++)
                r_j[s] <= '{ctr: aesctr_pkg::aes_round(r_j[s-1].ctr, i_rkeys[s],
                                                       s != NS - 1),
                            data: r_j[s-1].data, nbytes: r_j[s-1].nbytes};
        end
    end
endmodule

FILE: rtl/core/aes128_ctr_crypt.sv
// an input transfer passes through the job queue and then the round stages of the cipher pipeline
// throughput: one 16-byte block per cycle while neither side stalls, set by the unrolled 10-round pipeline
// input stalls while round keys are rebuilt, after a key write and after reset
// a result stall freezes the cipher pipeline; the 2-entry queue absorbs the input side
// reset (i_rst_n low, synchronous): key, start counter and counter go to zero,
// pipeline and queue empty
module aes128_ctr_crypt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  aesctr_pkg::t_in_item   i_item,
    output logic                   o_valid,
    input  logic                   i_stall,
    output aesctr_pkg::t_out_item  o_item,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [63:0]            i_cfg_data
);
    // configuration registers
    logic [63:0]        r_key_hi, r_key_lo, r_sc_hi, r_sc_lo;
    logic               r_key_load;
    logic [10:0][127:0] w_rkeys;
    logic               w_jv, w_jstall;
    aesctr_pkg::t_job   w_job;
    logic               w_key_busy;
    logic               w_front_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi   <= '0;
            r_key_lo   <= '0;
            r_sc_hi    <= '0;
            r_sc_lo    <= '0;
            r_key_load <= 1'b0;
        end else begin
            r_key_load <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aesctr_pkg::CFG_KEY_HIGH: begin
                        r_key_hi   <= i_cfg_data;
                        r_key_load <= 1'b1;
                    end
                    aesctr_pkg::CFG_KEY_LOW: begin
                        r_key_lo   <= i_cfg_data;
                        r_key_load <= 1'b1;
                    end
                    aesctr_pkg::CFG_START_HIGH: r_sc_hi <= i_cfg_data;
                    aesctr_pkg::CFG_START_LOW:  r_sc_lo <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // round key expansion, restarted in the cycle after a key write
    aesctr_keyexp u_keyexp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_key_load),
        .i_key   ({r_key_hi, r_key_lo}),
        .o_rkeys (w_rkeys),
        .o_busy  (w_key_busy)
    );

    // no input transfer until every round key is in place
    assign o_stall = w_front_stall || w_key_busy;

    // front: counter selection and the job queue
    aesctr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid && !w_key_busy),
        .i_item      (i_item),
        .o_stall     (w_front_stall),
        .i_start_ctr ({r_sc_hi, r_sc_lo}),
        .o_valid     (w_jv),
        .o_job       (w_job),
        .i_stall     (w_jstall)
    );

    // back: cipher pipeline and output masking
    aesctr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_jv),
        .i_job   (w_job),
        .o_stall (w_jstall),
        .i_rkeys (w_rkeys),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

    // a zero-count result carries all-zero data
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.result_bytes == 5'd0 |->
            o_item.result_high == 64'd0 && o_item.result_low == 64'd0)
        else $error("nonzero data on empty result");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    // result count never exceeds a block
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.result_bytes <= 5'd16)
        else $error("result count above sixteen");

endmodule

FILE: test/aes128_ctr_crypt_chk.sv
`timescale 1ns / 100ps

module aes128_ctr_crypt_chk (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_stall,
    input  aesctr_pkg::t_in_item  i_item,
    input  logic                  o_valid,
    input  logic                  o_stall,
    input  aesctr_pkg::t_out_item o_item,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [7:0]            sub_tab [256];
    logic [31:0]           key_sched [44];
    logic [127:0]          cipher_key;
    logic [127:0]          start_ctr;
    logic [127:0]          cur_ctr;
    aesctr_pkg::t_out_item crypt_q [$];

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = xtime(a);
        end
        return p;
    endfunction

    // s-box from the field inverse and the affine map
    initial begin
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++) begin
            inv = '0;
            for (int y = 1; y < 256; y++)
                if (gmul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_tab[x] = s;
        end
    end

    function automatic void build_schedule();
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        for (int i = 0; i < 4; i++) key_sched[i] = cipher_key[127-32*i -: 32];
        for (int i = 4; i < 44; i++) begin
            t = key_sched[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sub_tab[t[31:24]], sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]]};
                t ^= {rcon, 24'h0};
                rcon = xtime(rcon);
            end
            key_sched[i] = key_sched[i-4] ^ t;
        end
    endfunction

    function automatic logic [127:0] encrypt(input logic [127:0] blk);
        logic [7:0]  st [16];
        logic [7:0]  tmp [16];
        logic [7:0]  a, b, d, e, x;
        logic [31:0] w;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
        for (int rnd = 0; rnd <= 10; rnd++) begin
            if (rnd > 0) begin
                // sub bytes and shift rows together
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[4*c+r] = sub_tab[st[4*((c+r)%4)+r]];
                st = tmp;
                if (rnd < 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a = st[4*c]; b = st[4*c+1]; d = st[4*c+2]; e = st[4*c+3];
                        x = a ^ b ^ d ^ e;
                        st[4*c]   ^= x ^ xtime(a ^ b);
                        st[4*c+1] ^= x ^ xtime(b ^ d);
                        st[4*c+2] ^= x ^ xtime(d ^ e);
                        st[4*c+3] ^= x ^ xtime(e ^ a);
                    end
                end
            end
            for (int c = 0; c < 4; c++) begin
                w = key_sched[4*rnd+c];
                for (int j = 0; j < 4; j++) st[4*c+j] ^= w[31-8*j -: 8];
            end
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
        return res;
    endfunction

    function automatic aesctr_pkg::t_out_item crypt_block(input aesctr_pkg::t_in_item it);
        logic [4:0]            n;
        logic [127:0]          mask;
        logic [127:0]          res;
        aesctr_pkg::t_out_item o;
        n = (it.valid_bytes > 5'd16) ? 5'd16 : it.valid_bytes;
        if (it.restart) cur_ctr = start_ctr;
        if (n == 0) begin
            o = '0;
        end else begin
            mask = {128{1'b1}} << (8 * (16 - n));
            res = ({it.data_high, it.data_low} ^ encrypt(cur_ctr)) & mask;
            o.result_high = res[127:64];
            o.result_low = res[63:0];
            o.result_bytes = n;
            cur_ctr = cur_ctr + 128'd1;
        end
        return o;
    endfunction

    always @(posedge i_clk) begin
        aesctr_pkg::t_out_item want;
        if (!i_rst_n) begin
            cipher_key = '0;
            start_ctr = '0;
            cur_ctr = '0;
            build_schedule();
            crypt_q.delete();
        end else begin
            // result side first, so a transfer arriving with nothing queued is caught
            if (o_valid && !i_stall) begin
                if (crypt_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result transfer: %h", o_item);
                end else begin
                    want = crypt_q.pop_front();
                    if (o_item.result_high !== want.result_high
                        || o_item.result_low !== want.result_low
                        || o_item.result_bytes !== want.result_bytes) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %h %h %0d, actual %h %h %0d",
                                     want.result_high, want.result_low, want.result_bytes,
                                     o_item.result_high, o_item.result_low,
                                     o_item.result_bytes);
                    end
                end
            end
            if (i_valid && !o_stall) crypt_q.push_back(crypt_block(i_item));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aesctr_pkg::CFG_KEY_HIGH: begin
                        cipher_key[127:64] = i_cfg_data;
                        build_schedule();
                    end
                    aesctr_pkg::CFG_KEY_LOW: begin
                        cipher_key[63:0] = i_cfg_data;
                        build_schedule();
                    end
                    aesctr_pkg::CFG_START_HIGH: start_ctr[127:64] = i_cfg_data;
                    aesctr_pkg::CFG_START_LOW:  start_ctr[63:0] = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = crypt_q.size();
    end

endmodule

FILE: test/aes128_ctr_crypt_tb.sv
`timescale 1ns / 100ps

module aes128_ctr_crypt_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    aesctr_pkg::t_in_item  i_item;
    logic                  o_valid;
    logic                  i_stall;
    aesctr_pkg::t_out_item o_item;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_idx;
    logic [63:0]           i_cfg_data;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    aes128_ctr_crypt u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // scoreboard beside the block: predicts the keystream and compares
    aes128_ctr_crypt_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_stall      (i_stall),
        .i_item       (i_item),
        .o_valid      (o_valid),
        .o_stall      (o_stall),
        .o_item       (o_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver back-pressure, changed at the falling edge
    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // one register write, entered and left at a falling edge
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_setup(input logic [127:0] key, input logic [127:0] ctr0);
        write_reg(aesctr_pkg::CFG_KEY_HIGH, key[127:64]);
        write_reg(aesctr_pkg::CFG_KEY_LOW, key[63:0]);
        write_reg(aesctr_pkg::CFG_START_HIGH, ctr0[127:64]);
        write_reg(aesctr_pkg::CFG_START_LOW, ctr0[63:0]);
        // let the round keys re-expand before new blocks
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // drain: all results back, then the pipeline latency on top
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one block transfer, with a random sender gap in front
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic [4:0] nb, input logic rs);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_item.data_high = hi;
        i_item.data_low = lo;
        i_item.valid_bytes = nb;
        i_item.restart = rs;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_random(input int count);
        logic [4:0] nb;
        for (int k = 0; k < count; k++) begin
            // mostly full blocks; partial, zero and oversized counts now and then
            case ($urandom_range(9))
                0, 1:    nb = 5'($urandom_range(1, 15));
                2:       nb = 5'($urandom_range(0, 31));
                default: nb = 5'd16;
            endcase
            send_block({$urandom, $urandom}, {$urandom, $urandom}, nb,
                       (k == 0) || ($urandom_range(99) < 3));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = aesctr_pkg::CFG_KEY_HIGH;
        i_cfg_data = '0;
        send_idle_pct = 12;
        recv_idle_pct = 86;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        // directed: zero key and counter straight out of reset
        send_block('0, '0, 5'd16, 1'b0);
        send_block({64{1'b1}}, {64{1'b1}}, 5'd16, 1'b0);
        drain();

        // directed: standard test key, counter restart, every count boundary
        load_setup(128'h2b7e151628aed2a6abf7158809cf4f3c,
                   128'hf0f1f2f3f4f5f6f7f8f9fafbfcfdfeff);
        send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
        send_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd16, 1'b0);
        send_block({64{1'b1}}, {64{1'b1}}, 5'd1, 1'b0);
        send_block({64{1'b1}}, {64{1'b1}}, 5'd7, 1'b0);
        send_block({64{1'b1}}, {64{1'b1}}, 5'd8, 1'b0);
        send_block({64{1'b1}}, {64{1'b1}}, 5'd9, 1'b0);
        send_block({64{1'b1}}, {64{1'b1}}, 5'd15, 1'b0);
        // zero count: no keystream used, counter holds
        send_block({64{1'b1}}, {64{1'b1}}, 5'd0, 1'b0);
        send_block('0, '0, 5'd16, 1'b0);
        // oversized counts clamp to a full block
        send_block({64{1'b1}}, {64{1'b1}}, 5'd17, 1'b0);
        send_block({64{1'b1}}, {64{1'b1}}, 5'd31, 1'b0);
        // zero count with restart still reloads
        send_block('0, '0, 5'd0, 1'b1);
        send_block('0, '0, 5'd16, 1'b0);
        send_block(64'h30c81c46a35ce411, 64'he5fbc1191a0a52ef, 5'd12, 1'b1);
        drain();

        // start counter written but not yet restarted keeps the running count
        write_reg(aesctr_pkg::CFG_START_LOW, 64'h0123456789abcdef);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        send_block('0, '0, 5'd16, 1'b0);
        send_block('0, '0, 5'd16, 1'b1);
        drain();

        // all-ones key, carry from the low counter half into the high half
        load_setup({128{1'b1}}, {64'h0, 64'hffff_ffff_ffff_fff0});
        send_random(240);
        // sender holds off until every result is back
        while (pending != 0) @(negedge i_clk);
        send_random(240);
        drain();

        // sender now mostly idle, receiver rarely stalls; counter wraps at 2^128
        send_idle_pct = 86;
        recv_idle_pct = 12;
        load_setup('0, {128{1'b1}} - 128'd100);
        send_random(480);
        drain();

        // no idling at all, random setup
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_setup({$urandom, $urandom, $urandom, $urandom},
                   {$urandom, $urandom, $urandom, $urandom});
        send_random(480);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
